[rtl/ptw_pkg.sv]
// ----------------------------------------------------------------------------
// ptw_pkg
// Types and constants shared by the private timer and watchdog block.
// ----------------------------------------------------------------------------
package ptw_pkg;

    // Operation codes carried by the mode field of an input transfer.
    typedef enum logic [1:0] {
        MODE_READ  = 2'd0,
        MODE_WRITE = 2'd1,
        MODE_TICK  = 2'd2,
        MODE_NOP   = 2'd3
    } mode_t;

    // Fixed output widths and CPU limit.
    localparam int CPU_SLOTS = 4;
    localparam int IRQ_W     = 2 * CPU_SLOTS;
    localparam int RST_W     = CPU_SLOTS;

    // Access window: everything at or above this offset is an error.
    localparam logic [5:0] OFFSET_LIMIT = 6'h38;
    localparam logic [5:0] WDT_BASE     = 6'h20;

    // Register offsets inside one counter's window.
    localparam logic [4:0] OFF_LOAD    = 5'h00;
    localparam logic [4:0] OFF_COUNT   = 5'h04;
    localparam logic [4:0] OFF_CTRL    = 5'h08;
    localparam logic [4:0] OFF_INTSTAT = 5'h0C;
    localparam logic [4:0] OFF_RSTSTAT = 5'h10;
    localparam logic [4:0] OFF_DISABLE = 5'h14;

    // Control register layout.
    localparam int CTL_EN  = 0;
    localparam int CTL_AR  = 1;
    localparam int CTL_IE  = 2;
    localparam int CTL_WDM = 3;
    localparam logic [31:0] CTL_RESVD      = 32'hFFFF00F8;
    localparam logic [15:0] CTL_WRITE_MASK = ~CTL_RESVD[15:0];

    // Watchdog disable key sequence.
    localparam logic [31:0] KEY_ONE = 32'h12345678;
    localparam logic [31:0] KEY_TWO = 32'h87654321;

    // Decoded bus access.
    typedef struct packed {
        logic       rd;
        logic       wr;
        logic       tick;
        logic       err;
        logic       wdt;
        logic [2:0] idx;
        logic [4:0] local_off;
    } acc_t;

    // Command to one counter lane.
    typedef struct packed {
        logic        tick;
        logic        write;
        logic [4:0]  local_off;
        logic [31:0] data;
    } lane_cmd_t;

    // Visible state of one counter lane.
    typedef struct packed {
        logic [31:0] load;
        logic [31:0] count;
        logic [15:0] ctrl;
        logic        irq_st;
        logic        rst_st;
    } lane_state_t;

endpackage

[rtl/ptw_decode.sv]
// ----------------------------------------------------------------------------
// ptw_decode
// Decodes a registered bus transfer into operation, target counter and
// access error.
// ----------------------------------------------------------------------------
module ptw_decode
    import ptw_pkg::*;
#(
    parameter int NUM_CPUS = 4
)
(
    input  logic [1:0] mode,
    input  logic [1:0] cpu,
    input  logic [5:0] offset,
    input  logic [2:0] active_cpus,
    output acc_t       acc
);

    logic cpu_ok;
    logic is_access;

    always_comb
    begin
        cpu_ok = ({1'b0, cpu} < active_cpus) && ({1'b0, cpu} < 3'(NUM_CPUS));
        is_access = 1'b0;
        acc = '0;
        case (mode_t'(mode))
            MODE_READ:
            begin
                acc.rd = 1'b1;
                is_access = 1'b1;
            end
            MODE_WRITE:
            begin
                acc.wr = 1'b1;
                is_access = 1'b1;
            end
            MODE_TICK:
            begin
                acc.tick = 1'b1;
            end
            default:
            begin
                acc.rd = 1'b0;
            end
        endcase
        acc.err = is_access && ((offset >= OFFSET_LIMIT) || !cpu_ok);
        acc.wdt = (offset >= WDT_BASE);
        acc.idx = {cpu, acc.wdt};
        // The watchdog window starts at 0x20, so the low five bits are
        // already the offset inside the selected counter's window.
        acc.local_off = offset[4:0];
    end

endmodule

[rtl/ptw_lane.sv]
// ----------------------------------------------------------------------------
// ptw_lane
// One 32-bit down-counter with its load, control and status registers,
// acting as either the private timer or the watchdog of one CPU.
// ----------------------------------------------------------------------------
module ptw_lane
    import ptw_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        watchdog,
    input  lane_cmd_t   cmd,
    output lane_state_t state,
    output logic        irq_after,
    output logic        rst_after
);

    logic [31:0] load_reg, load_next;
    logic [31:0] count_reg, count_next;
    logic [15:0] ctrl_reg, ctrl_next;
    logic        irq_reg, irq_next;
    logic        rst_reg, rst_next;
    logic        armed_reg, armed_next;
    logic [31:0] count_dec;
    logic [15:0] ctrl_wr;

    always_comb
    begin
        load_next  = load_reg;
        count_next = count_reg;
        ctrl_next  = ctrl_reg;
        irq_next   = irq_reg;
        rst_next   = rst_reg;
        armed_next = armed_reg;
        count_dec  = count_reg - 32'd1;
        ctrl_wr    = cmd.data[15:0] & CTL_WRITE_MASK;
        // Watchdog mode can only be set on the watchdog; a control write never clears it.
        if (watchdog && (cmd.data[CTL_WDM] || ctrl_reg[CTL_WDM]))
        begin
            ctrl_wr[CTL_WDM] = 1'b1;
        end

        if (cmd.tick)
        begin
            if (ctrl_reg[CTL_EN] && (count_reg != 32'd0))
            begin
                count_next = count_dec;
                if (count_dec == 32'd0)
                begin
                    irq_next = 1'b1;
                    if (ctrl_reg[CTL_WDM])
                    begin
                        rst_next = 1'b1;
                    end
                    if (ctrl_reg[CTL_AR])
                    begin
                        count_next = load_reg;
                    end
                end
            end
        end
        else if (cmd.write)
        begin
            case (cmd.local_off)
                OFF_LOAD:
                begin
                    load_next  = cmd.data;
                    count_next = cmd.data;
                end
                OFF_COUNT:
                begin
                    count_next = cmd.data;
                end
                OFF_CTRL:
                begin
                    ctrl_next = ctrl_wr;
                    // Enabling an expired auto-reload counter restarts it.
                    if (!ctrl_reg[CTL_EN] && ctrl_wr[CTL_EN] && ctrl_wr[CTL_AR]
                        && (count_reg == 32'd0))
                    begin
                        count_next = load_reg;
                    end
                end
                OFF_INTSTAT:
                begin
                    if (cmd.data[0])
                    begin
                        irq_next = 1'b0;
                    end
                end
                OFF_RSTSTAT:
                begin
                    if (watchdog && cmd.data[0])
                    begin
                        rst_next = 1'b0;
                    end
                end
                OFF_DISABLE:
                begin
                    if (watchdog)
                    begin
                        if (cmd.data == KEY_ONE)
                        begin
                            armed_next = 1'b1;
                        end
                        else if ((cmd.data == KEY_TWO) && armed_reg)
                        begin
                            ctrl_next[CTL_WDM] = 1'b0;
                            armed_next = 1'b0;
                        end
                        else
                        begin
                            armed_next = 1'b0;
                        end
                    end
                end
                default:
                begin
                    armed_next = armed_reg;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            load_reg  <= '0;
            count_reg <= '0;
            ctrl_reg  <= '0;
            irq_reg   <= 1'b0;
            rst_reg   <= 1'b0;
            armed_reg <= 1'b0;
        end
        else
        begin
            load_reg  <= load_next;
            count_reg <= count_next;
            ctrl_reg  <= ctrl_next;
            irq_reg   <= irq_next;
            rst_reg   <= rst_next;
            armed_reg <= armed_next;
        end
    end

    assign state.load   = load_reg;
    assign state.count  = count_reg;
    assign state.ctrl   = ctrl_reg;
    assign state.irq_st = irq_reg;
    assign state.rst_st = rst_reg;

    assign irq_after = ctrl_next[CTL_EN] & ctrl_next[CTL_IE] & irq_next;
    assign rst_after = rst_next;

endmodule

[rtl/private_timer_watchdog_regs.sv]
// ----------------------------------------------------------------------------
// private_timer_watchdog_regs
// Per-CPU private timer and watchdog register block.
//
// Each CPU owns a pair of 32-bit down-counters: a private timer at byte
// offsets 0x00-0x1F and a watchdog at 0x20-0x37. A transfer on the input
// channel is a register read, a register write from the CPU named in the
// transfer, one counting tick that advances every enabled counter of every
// active CPU, or a no-op. Each input transfer yields exactly one output transfer
// carrying the read data, an access error flag, and the interrupt and reset
// request lines as they stand after that transfer has taken effect. The block
// takes one transfer per clock cycle while the output is not stalled: the
// transfer is captured in an input register, and once the result register is
// free the state update of all counters fills the result register. A stalled
// output holds the input register, so throughput then follows the output side.
// The active_cpus register is written through cfg_write_en and
// cfg_write_data and must only change while the block is idle; it resets to 4.
// ----------------------------------------------------------------------------
module private_timer_watchdog_regs
    import ptw_pkg::*;
#(
    parameter int NUM_CPUS = 4
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_write_en,
    input  logic [2:0]  cfg_write_data,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [1:0]  mode,
    input  logic [1:0]  cpu,
    input  logic [5:0]  offset,
    input  logic [31:0] write_data,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [31:0] read_data,
    output logic        access_error,
    output logic [7:0]  irq_lines,
    output logic [3:0]  reset_requests
);

    localparam int NTIMERS = 2 * NUM_CPUS;
    localparam int LW      = $clog2(NTIMERS);

    // Configuration.
    logic [2:0] active_cpus_reg;

    // Input register stage.
    logic        in_valid_reg;
    logic [1:0]  mode_reg;
    logic [1:0]  cpu_reg;
    logic [5:0]  offset_reg;
    logic [31:0] write_data_reg;

    // Result register stage.
    logic        out_valid_reg;
    logic [31:0] read_data_reg, read_data_next;
    logic        access_error_reg;
    logic [7:0]  irq_lines_reg;
    logic [3:0]  reset_requests_reg;

    logic        fire;
    acc_t        acc;
    lane_state_t lane_st [NTIMERS];
    lane_state_t sel_st;
    logic [IRQ_W-1:0] irq_vec;
    logic [RST_W-1:0] rst_vec;
    logic [NTIMERS-1:0] rst_lane;

    // The stored item is executed whenever the result register is free or
    // is being emptied in this same cycle.
    assign fire     = in_valid_reg && (!out_valid_reg || out_ready);
    assign in_ready = !in_valid_reg || fire;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            active_cpus_reg <= 3'd4;
        end
        else if (cfg_write_en)
        begin
            active_cpus_reg <= cfg_write_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            in_valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            mode_reg       <= mode;
            cpu_reg        <= cpu;
            offset_reg     <= offset;
            write_data_reg <= write_data;
        end
    end

    ptw_decode #(
        .NUM_CPUS (NUM_CPUS)
    ) u_decode (
        .mode        (mode_reg),
        .cpu         (cpu_reg),
        .offset      (offset_reg),
        .active_cpus (active_cpus_reg),
        .acc         (acc)
    );

    // One lane per counter; even lanes are private timers, odd lanes are
    // watchdogs. A tick reaches only lanes whose CPU is active, and a write
    // reaches only the lane that the decoder selected.
    for (genvar t = 0; t < NTIMERS; t++)
    begin : g_lane
        lane_cmd_t cmd;
        logic      lane_active;
        logic      irq_after;

        assign lane_active   = (3'(t / 2) < active_cpus_reg);
        assign cmd.tick      = fire && acc.tick && lane_active;
        assign cmd.write     = fire && acc.wr && !acc.err && (acc.idx == 3'(t));
        assign cmd.local_off = acc.local_off;
        assign cmd.data      = write_data_reg;

        ptw_lane u_lane (
            .clk       (clk),
            .rst_n     (rst_n),
            .watchdog  (1'(t % 2)),
            .cmd       (cmd),
            .state     (lane_st[t]),
            .irq_after (irq_after),
            .rst_after (rst_lane[t])
        );

        assign irq_vec[t] = irq_after;
    end

    for (genvar t = NTIMERS; t < IRQ_W; t++)
    begin : g_irq_pad
        assign irq_vec[t] = 1'b0;
    end

    for (genvar c = 0; c < RST_W; c++)
    begin : g_rst
        if (c < NUM_CPUS)
        begin : g_used
            assign rst_vec[c] = rst_lane[2 * c + 1];
        end
        else
        begin : g_pad
            assign rst_vec[c] = 1'b0;
        end
    end

    // Register read: the selected lane's state is muxed by the window offset.
    // Unaligned offsets, holes and the disable register read as zero.
    assign sel_st = lane_st[acc.idx[LW-1:0]];

    always_comb
    begin
        read_data_next = '0;
        if (acc.rd && !acc.err)
        begin
            case (acc.local_off)
                OFF_LOAD:    read_data_next = sel_st.load;
                OFF_COUNT:   read_data_next = sel_st.count;
                OFF_CTRL:    read_data_next = {16'd0, sel_st.ctrl};
                OFF_INTSTAT: read_data_next = {31'd0, sel_st.irq_st};
                OFF_RSTSTAT: read_data_next = {31'd0, acc.wdt & sel_st.rst_st};
                default:     read_data_next = '0;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (fire)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (fire)
        begin
            read_data_reg      <= read_data_next;
            access_error_reg   <= acc.err;
            irq_lines_reg      <= irq_vec;
            reset_requests_reg <= rst_vec;
        end
    end

    assign out_valid      = out_valid_reg;
    assign read_data      = read_data_reg;
    assign access_error   = access_error_reg;
    assign irq_lines      = irq_lines_reg;
    assign reset_requests = reset_requests_reg;

`ifndef SYNTHESIS
    // An executed transfer always produces a result in the next cycle.
    a_fire_gives_result: assert property (@(posedge clk) disable iff (!rst_n)
        fire |=> out_valid)
        else $error("executed transfer did not produce a result");

    // A stored transfer never waits while the result register is empty.
    a_no_idle_stall: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid_reg && !out_valid_reg) |-> fire)
        else $error("stored transfer stalled with empty result register");

    // An access error always comes with zero read data.
    a_err_zero_data: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && access_error) |-> (read_data == 32'd0))
        else $error("access error with nonzero read data");

    // A tick never reports an access error.
    a_tick_no_err: assert property (@(posedge clk) disable iff (!rst_n)
        (fire && acc.tick) |=> !access_error)
        else $error("tick reported an access error");
`endif

endmodule
